>>> src/ust_pkg.sv
package ust_pkg;

   localparam int OFFSET_BITS_DEFAULT = 32;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      ENC_AUTO    = 2'd0,
      ENC_UTF8    = 2'd1,
      ENC_UTF16LE = 2'd2,
      ENC_UTF16BE = 2'd3
   } enc_type;

   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_END   = 2'd1,
      KIND_ERROR = 2'd2
   } out_kind_type;

   typedef enum logic [0:0] {
      CSR_ENCODING_MODE = 1'b0,
      CSR_MAX_LENGTH    = 1'b1
   } csr_index_type;

   localparam logic [3:0] ERR_BAD_LEAD          = 4'd0;
   localparam logic [3:0] ERR_INCOMPLETE_UTF8   = 4'd1;
   localparam logic [3:0] ERR_BAD_TRAIL         = 4'd2;
   localparam logic [3:0] ERR_OVERLONG          = 4'd3;
   localparam logic [3:0] ERR_BAD_CODEPOINT     = 4'd4;
   localparam logic [3:0] ERR_INCOMPLETE_UTF16  = 4'd5;
   localparam logic [3:0] ERR_STRAY_LOW         = 4'd6;
   localparam logic [3:0] ERR_INCOMPLETE_PAIR   = 4'd7;
   localparam logic [3:0] ERR_MISSING_LOW       = 4'd8;
   localparam logic [3:0] ERR_DISALLOWED        = 4'd9;
   localparam logic [3:0] ERR_TOO_LONG          = 4'd10;

   typedef struct packed {
      out_kind_type       kind;
      logic [20:0]        cp;
      logic [2:0]         nb;
      logic [3:0]         code;
      logic [31:0]        offset;
      logic signed [21:0] value;
   } job_type;

   function automatic logic allowed(input logic [20:0] v);
      return v == 21'h09 || v == 21'h0A || v == 21'h0D
         || (v >= 21'h20 && v <= 21'h7E) || v == 21'h85
         || (v >= 21'hA0 && v <= 21'hD7FF)
         || (v >= 21'hE000 && v <= 21'hFFFD)
         || (v >= 21'h10000 && v <= 21'h10FFFF);
   endfunction

endpackage

>>> src/ust_req_if.sv
interface ust_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] in_byte;

   modport source (output valid, output action, output in_byte, input ready);
   modport sink (input valid, input action, input in_byte, output ready);
endinterface

>>> src/ust_rsp_if.sv
interface ust_rsp_if;
   logic                 valid;
   logic                 ready;
   ust_pkg::out_kind_type kind;
   logic [7:0]           out_byte;
   logic [3:0]           error_code;
   logic [31:0]          error_offset;
   logic signed [21:0]   error_value;
   logic                 last;

   modport source (output valid, output kind, output out_byte, output error_code,
                   output error_offset, output error_value, output last, input ready);
   modport sink (input valid, input kind, input out_byte, input error_code,
                 input error_offset, input error_value, input last, output ready);
endinterface

>>> src/ust_front.sv
module ust_front #(
   parameter int OFFSET_BITS = ust_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   ust_req_if.sink           req,
   input  ust_pkg::enc_type  mode,
   input  logic [31:0]       max_len,
   input  logic              q_full,
   output logic              job_valid,
   output ust_pkg::job_type  job
);

   localparam int CW = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;

   ust_pkg::enc_type enc_ff, enc_in;
   logic [1:0]  mark_cnt_ff, mark_cnt_in;
   logic [7:0]  mark0_ff, mark0_in;
   logic [20:0] acc_ff, acc_in;
   logic [2:0]  sw_ff, sw_in;
   logic [2:0]  sc_ff, sc_in;
   logic [15:0] hi_ff, hi_in;
   logic [OFFSET_BITS-1:0] ofs_ff, ofs_in;
   logic        failed_ff, failed_in;
   logic        finished_ff, finished_in;
   logic        tbad_ff, tbad_in;
   logic [OFFSET_BITS-1:0] tpos_ff, tpos_in;
   logic [7:0]  toct_ff, toct_in;

   function automatic logic [31:0] to32(input logic [OFFSET_BITS-1:0] p);
      logic [CW-1:0] w;
      w = CW'(p);
      return w[31:0];
   endfunction

   function automatic ust_pkg::job_type mk_err(input logic [3:0] code,
                                               input logic [OFFSET_BITS-1:0] p,
                                               input logic signed [21:0] val);
      ust_pkg::job_type j;
      j = '0;
      j.kind = ust_pkg::KIND_ERROR;
      j.nb = 3'd1;
      j.code = code;
      j.offset = to32(p);
      j.value = val;
      return j;
   endfunction

   function automatic ust_pkg::job_type mk_char(input logic [20:0] v,
                                                input logic [OFFSET_BITS-1:0] p);
      ust_pkg::job_type j;
      j = '0;
      if (!ust_pkg::allowed(v)) begin
         j = mk_err(ust_pkg::ERR_DISALLOWED, p, signed'({1'b0, v}));
      end else begin
         j.kind = ust_pkg::KIND_BYTE;
         j.cp = v;
         if (v <= 21'h7F) j.nb = 3'd1;
         else if (v <= 21'h7FF) j.nb = 3'd2;
         else if (v <= 21'hFFFF) j.nb = 3'd3;
         else j.nb = 3'd4;
      end
      return j;
   endfunction

   function automatic logic [OFFSET_BITS-1:0] cs(input logic [OFFSET_BITS-1:0] p,
                                                 input logic [2:0] n);
      logic [OFFSET_BITS-1:0] ne;
      ne = OFFSET_BITS'(n);
      return (p >= ne) ? p - ne : '0;
   endfunction

   logic [7:0]  b;
   logic        accept;
   logic        do_feed;
   ust_pkg::enc_type feed_enc, eff;
   logic [OFFSET_BITS-1:0] pos, start;
   logic [2:0]  w, sc_n;
   logic        tb;
   logic [OFFSET_BITS-1:0] tp;
   logic [7:0]  to;
   logic [20:0] acc_n;
   logic [15:0] unit;

   assign req.ready = !q_full;
   assign accept = req.valid && !q_full;
   assign b = req.in_byte;
   assign pos = ofs_ff;

   always_comb begin
      enc_in = enc_ff;
      mark_cnt_in = mark_cnt_ff;
      mark0_in = mark0_ff;
      acc_in = acc_ff;
      sw_in = sw_ff;
      sc_in = sc_ff;
      hi_in = hi_ff;
      ofs_in = ofs_ff;
      failed_in = failed_ff;
      finished_in = finished_ff;
      tbad_in = tbad_ff;
      tpos_in = tpos_ff;
      toct_in = toct_ff;
      job = '0;
      job_valid = 1'b0;
      do_feed = 1'b0;
      feed_enc = enc_ff;
      eff = enc_ff;
      start = '0;
      w = '0;
      sc_n = '0;
      tb = 1'b0;
      tp = '0;
      to = '0;
      acc_n = '0;
      unit = '0;
      if (accept && !failed_ff && !finished_ff) begin
         if (req.action) begin
            job_valid = 1'b1;
            if (enc_ff == ust_pkg::ENC_AUTO && mark_cnt_ff != 2'd0) begin
               enc_in = ust_pkg::ENC_UTF8;
               mark_cnt_in = 2'd0;
               if (mark_cnt_ff == 2'd1 && mark0_ff != 8'hEF)
                  job = mk_err(ust_pkg::ERR_BAD_LEAD, '0, signed'({14'd0, mark0_ff}));
               else
                  job = mk_err(ust_pkg::ERR_INCOMPLETE_UTF8, '0, '1);
            end else begin
               if (enc_ff == ust_pkg::ENC_AUTO)
                  eff = (mode != ust_pkg::ENC_AUTO) ? mode : ust_pkg::ENC_UTF8;
               enc_in = eff;
               if (eff == ust_pkg::ENC_UTF8 && sc_ff != 3'd0)
                  job = mk_err(ust_pkg::ERR_INCOMPLETE_UTF8, cs(ofs_ff, sc_ff), '1);
               else if (eff != ust_pkg::ENC_UTF8 && sc_ff == 3'd1)
                  job = mk_err(ust_pkg::ERR_INCOMPLETE_UTF16, cs(ofs_ff, sc_ff), '1);
               else if (eff != ust_pkg::ENC_UTF8 && sc_ff >= 3'd2)
                  job = mk_err(ust_pkg::ERR_INCOMPLETE_PAIR, cs(ofs_ff, sc_ff), '1);
               else begin
                  job.kind = ust_pkg::KIND_END;
                  job.nb = 3'd1;
                  finished_in = 1'b1;
               end
            end
         end else if (CW'(ofs_ff) >= CW'(max_len)) begin
            job_valid = 1'b1;
            job = mk_err(ust_pkg::ERR_TOO_LONG, ofs_ff, '1);
         end else begin
            ofs_in = (ofs_ff == '1) ? ofs_ff : ofs_ff + 1'b1;
            if (enc_ff == ust_pkg::ENC_AUTO && mark_cnt_ff == 2'd0
                && mode != ust_pkg::ENC_AUTO) begin
               enc_in = mode;
               do_feed = 1'b1;
               feed_enc = mode;
            end else if (enc_ff == ust_pkg::ENC_AUTO) begin
               case (mark_cnt_ff)
                  2'd0: begin
                     if (b == 8'hEF || b == 8'hFE || b == 8'hFF) begin
                        mark0_in = b;
                        mark_cnt_in = 2'd1;
                     end else begin
                        enc_in = ust_pkg::ENC_UTF8;
                        do_feed = 1'b1;
                        feed_enc = ust_pkg::ENC_UTF8;
                     end
                  end
                  2'd1: begin
                     if (mark0_ff == 8'hFF && b == 8'hFE) begin
                        enc_in = ust_pkg::ENC_UTF16LE;
                        mark_cnt_in = 2'd0;
                     end else if (mark0_ff == 8'hFE && b == 8'hFF) begin
                        enc_in = ust_pkg::ENC_UTF16BE;
                        mark_cnt_in = 2'd0;
                     end else if (mark0_ff == 8'hEF && b == 8'hBB) begin
                        mark_cnt_in = 2'd2;
                     end else begin
                        enc_in = ust_pkg::ENC_UTF8;
                        mark_cnt_in = 2'd0;
                        if (mark0_ff != 8'hEF) begin
                           job_valid = 1'b1;
                           job = mk_err(ust_pkg::ERR_BAD_LEAD, '0,
                                        signed'({14'd0, mark0_ff}));
                        end else begin
                           acc_in = {11'd0, 4'hF, b[5:0]};
                           sw_in = 3'd3;
                           sc_in = 3'd2;
                           tbad_in = (b[7:6] != 2'b10);
                           tpos_in = OFFSET_BITS'(1);
                           toct_in = b;
                        end
                     end
                  end
                  default: begin
                     enc_in = ust_pkg::ENC_UTF8;
                     mark_cnt_in = 2'd0;
                     if (b != 8'hBF) begin
                        job_valid = 1'b1;
                        if (b[7:6] != 2'b10)
                           job = mk_err(ust_pkg::ERR_BAD_TRAIL, OFFSET_BITS'(2),
                                        signed'({14'd0, b}));
                        else
                           job = mk_char({15'h3FB, b[5:0]}, '0);
                     end
                  end
               endcase
            end else begin
               do_feed = 1'b1;
               feed_enc = enc_ff;
            end
         end
      end

      if (do_feed) begin
         if (feed_enc == ust_pkg::ENC_UTF8) begin
            if (sc_ff == 3'd0) begin
               if (b < 8'h80) begin
                  job_valid = 1'b1;
                  job = mk_char({13'd0, b}, pos);
               end else begin
                  if (b[7:5] == 3'b110) w = 3'd2;
                  else if (b[7:4] == 4'b1110) w = 3'd3;
                  else if (b[7:3] == 5'b11110) w = 3'd4;
                  else w = 3'd0;
                  if (w == 3'd0) begin
                     job_valid = 1'b1;
                     job = mk_err(ust_pkg::ERR_BAD_LEAD, pos, signed'({14'd0, b}));
                  end else begin
                     if (w == 3'd2) acc_in = {16'd0, b[4:0]};
                     else if (w == 3'd3) acc_in = {17'd0, b[3:0]};
                     else acc_in = {18'd0, b[2:0]};
                     sw_in = w;
                     sc_in = 3'd1;
                     tbad_in = 1'b0;
                  end
               end
            end else begin
               start = cs(pos, sc_ff);
               tb = tbad_ff;
               tp = tpos_ff;
               to = toct_ff;
               if (b[7:6] != 2'b10 && !tbad_ff) begin
                  tb = 1'b1;
                  tp = pos;
                  to = b;
               end
               tbad_in = tb;
               tpos_in = tp;
               toct_in = to;
               acc_n = {acc_ff[14:0], b[5:0]};
               acc_in = acc_n;
               sc_n = sc_ff + 3'd1;
               if (sc_n < sw_ff) begin
                  sc_in = sc_n;
               end else begin
                  sc_in = 3'd0;
                  job_valid = 1'b1;
                  if (tb)
                     job = mk_err(ust_pkg::ERR_BAD_TRAIL, tp, signed'({14'd0, to}));
                  else if ((sw_ff == 3'd2 && acc_n < 21'h80)
                           || (sw_ff == 3'd3 && acc_n < 21'h800)
                           || (sw_ff == 3'd4 && acc_n < 21'h10000))
                     job = mk_err(ust_pkg::ERR_OVERLONG, start, '1);
                  else if ((acc_n >= 21'hD800 && acc_n <= 21'hDFFF)
                           || acc_n > 21'h10FFFF)
                     job = mk_err(ust_pkg::ERR_BAD_CODEPOINT, start,
                                  signed'({1'b0, acc_n}));
                  else
                     job = mk_char(acc_n, start);
               end
            end
         end else begin
            start = cs(pos, sc_ff);
            if (sc_ff == 3'd0 || sc_ff == 3'd2) begin
               acc_in = {13'd0, b};
               sc_in = sc_ff + 3'd1;
            end else begin
               unit = (feed_enc == ust_pkg::ENC_UTF16LE) ? {b, acc_ff[7:0]}
                                                         : {acc_ff[7:0], b};
               if (sc_ff == 3'd1) begin
                  if (unit[15:10] == 6'b110111) begin
                     job_valid = 1'b1;
                     job = mk_err(ust_pkg::ERR_STRAY_LOW, start, signed'({6'd0, unit}));
                  end else if (unit[15:10] == 6'b110110) begin
                     hi_in = unit;
                     sc_in = 3'd2;
                  end else begin
                     sc_in = 3'd0;
                     job_valid = 1'b1;
                     job = mk_char({5'd0, unit}, start);
                  end
               end else begin
                  sc_in = 3'd0;
                  job_valid = 1'b1;
                  if (unit[15:10] != 6'b110111)
                     job = mk_err(ust_pkg::ERR_MISSING_LOW, start + OFFSET_BITS'(2),
                                  signed'({6'd0, unit}));
                  else
                     job = mk_char(21'h10000 + {1'b0, hi_ff[9:0], unit[9:0]}, start);
               end
            end
         end
      end

      if (job_valid && job.kind == ust_pkg::KIND_ERROR) begin
         failed_in = 1'b1;
         sc_in = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enc_ff <= ust_pkg::ENC_AUTO;
         mark_cnt_ff <= '0;
         acc_ff <= '0;
         sw_ff <= '0;
         sc_ff <= '0;
         hi_ff <= '0;
         ofs_ff <= '0;
         failed_ff <= 1'b0;
         finished_ff <= 1'b0;
         tbad_ff <= 1'b0;
         tpos_ff <= '0;
         toct_ff <= '0;
      end else begin
         enc_ff <= enc_in;
         mark_cnt_ff <= mark_cnt_in;
         acc_ff <= acc_in;
         sw_ff <= sw_in;
         sc_ff <= sc_in;
         hi_ff <= hi_in;
         ofs_ff <= ofs_in;
         failed_ff <= failed_in;
         finished_ff <= finished_in;
         tbad_ff <= tbad_in;
         tpos_ff <= tpos_in;
         toct_ff <= toct_in;
      end
   end

   always_ff @(posedge clock) begin
      mark0_ff <= mark0_in;
   end

endmodule

>>> src/ust_queue.sv
module ust_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ust_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output ust_pkg::job_type head_job
);

   localparam int PW = (ust_pkg::QUEUE_DEPTH > 1) ? $clog2(ust_pkg::QUEUE_DEPTH) : 1;
   localparam int CNTW = $clog2(ust_pkg::QUEUE_DEPTH + 1);

   ust_pkg::job_type mem [ust_pkg::QUEUE_DEPTH];
   logic [PW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;

   function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
      return (p == PW'(ust_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full = (cnt_ff == CNTW'(ust_pkg::QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_job = mem[rd_ff];

   always_comb begin
      wr_in = push ? nxt(wr_ff) : wr_ff;
      rd_in = pop ? nxt(rd_ff) : rd_ff;
      cnt_in = cnt_ff + CNTW'(push) - CNTW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem[wr_ff] <= push_job;
   end

endmodule

>>> src/ust_back.sv
module ust_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  ust_pkg::job_type head_job,
   output logic             pop,
   ust_rsp_if.source        rsp
);

   logic        valid_ff;
   logic [2:0]  idx_ff, idx_in;
   logic        load, is_last;
   logic [7:0]  piece;
   ust_pkg::out_kind_type kind_ff;
   logic [7:0]  byte_ff;
   logic [3:0]  code_ff;
   logic [31:0] offset_ff;
   logic signed [21:0] value_ff;
   logic        last_ff;

   assign load = head_valid && (!valid_ff || rsp.ready);
   assign is_last = (idx_ff == head_job.nb - 3'd1);
   assign pop = load && is_last;

   always_comb begin
      piece = 8'd0;
      if (head_job.kind == ust_pkg::KIND_BYTE) begin
         if (idx_ff == 3'd0) begin
            case (head_job.nb)
               3'd1: piece = {1'b0, head_job.cp[6:0]};
               3'd2: piece = {3'b110, head_job.cp[10:6]};
               3'd3: piece = {4'b1110, head_job.cp[15:12]};
               default: piece = {5'b11110, head_job.cp[20:18]};
            endcase
         end else begin
            case (head_job.nb - idx_ff)
               3'd1: piece = {2'b10, head_job.cp[5:0]};
               3'd2: piece = {2'b10, head_job.cp[11:6]};
               default: piece = {2'b10, head_job.cp[17:12]};
            endcase
         end
      end
      idx_in = idx_ff;
      if (load) idx_in = is_last ? 3'd0 : idx_ff + 3'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
         if (load) valid_ff <= 1'b1;
         else if (rsp.ready) valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= head_job.kind;
         byte_ff <= piece;
         code_ff <= head_job.code;
         offset_ff <= head_job.offset;
         value_ff <= head_job.value;
         last_ff <= is_last;
      end
   end

   assign rsp.valid = valid_ff;
   assign rsp.kind = kind_ff;
   assign rsp.out_byte = byte_ff;
   assign rsp.error_code = code_ff;
   assign rsp.error_offset = offset_ff;
   assign rsp.error_value = value_ff;
   assign rsp.last = last_ff;

endmodule

>>> src/unicode_stream_transcoder_top.sv
// Byte stream to UTF-8 transcoder. One raw byte per request transaction, closed by an
// end-of-stream transaction. The front stage decodes each byte combinationally into a
// character, terminator or error job and queues it (two entries); the back stage
// writes one UTF-8 byte per cycle while the receiver is ready, and input bytes are
// taken every cycle while the queue has room. Sustained rate with a ready receiver is
// one input per cycle for ASCII, set by the UTF-8 byte count of each character
// otherwise. Errors are reported once; afterwards the block gives no responses.
module unicode_stream_transcoder_top #(
   parameter int OFFSET_BITS = ust_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   ust_req_if.sink   req_ch,
   ust_rsp_if.source rsp_ch,
   input  logic      csr_write_enable,
   input  ust_pkg::csr_index_type csr_index,
   input  logic [31:0] csr_write_data
);

   ust_pkg::enc_type mode_ff;
   logic [31:0]      max_len_ff;
   logic             q_full, job_valid, head_valid, pop;
   ust_pkg::job_type job, head_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ust_pkg::ENC_AUTO;
         max_len_ff <= '1;
      end else if (csr_write_enable) begin
         case (csr_index)
            ust_pkg::CSR_ENCODING_MODE: mode_ff <= ust_pkg::enc_type'(csr_write_data[1:0]);
            ust_pkg::CSR_MAX_LENGTH:    max_len_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   ust_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .mode      (mode_ff),
      .max_len   (max_len_ff),
      .q_full    (q_full),
      .job_valid (job_valid),
      .job       (job)
   );

   ust_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_valid),
      .push_job   (job),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   ust_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp        (rsp_ch)
   );

endmodule

>>> dv/unicode_stream_transcoder_top_tb.sv
module unicode_stream_transcoder_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      ust_pkg::out_kind_type kind;
      logic [7:0]            out_byte;
      logic [3:0]            code;
      logic [31:0]           offset;
      logic signed [21:0]    value;
      logic                  last;
   } utf8_result_type;

   typedef struct {
      logic [20:0] cp;
      bit          typed;
   } char_row_type;

   localparam longint unsigned OFFSET_MAX = 64'hFFFF_FFFF;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   ust_pkg::csr_index_type csr_index;
   logic [31:0] csr_write_data;

   ust_req_if req ();
   ust_rsp_if rsp ();

   unicode_stream_transcoder_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req),
      .rsp_ch           (rsp),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // predictor state
   logic [1:0]       mode_reg;
   logic [31:0]      limit_reg;
   ust_pkg::enc_type cur_enc;
   logic [7:0]       held_mark [3];
   int unsigned      held_count;
   logic [20:0]      acc;
   int unsigned      seq_len;
   int unsigned      seq_got;
   logic [15:0]      high_sur;
   longint unsigned  rx_offset;
   bit               stream_failed;
   bit               stream_done;
   bit               trail_err;
   longint unsigned  trail_at;
   logic [7:0]       trail_val;

   utf8_result_type  utf8_expected_q [$];
   utf8_result_type  last_predicted;
   int unsigned      predicted_total;
   int unsigned      step_count;

   int unsigned      errors;
   int unsigned      checked;
   int unsigned      chars_sent;
   bit               gaps_on;
   ust_pkg::enc_type stream_enc;
   logic [7:0]       byte_q [$];

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("timeout at %0t", $time);
      $display("*** FAILED ***");
      $finish;
   end

   function automatic void push_result(ust_pkg::out_kind_type k, logic [7:0] b,
                                       logic [3:0] c, longint unsigned off,
                                       logic signed [21:0] v);
      utf8_result_type r;
      if (step_count >= 4) return;
      r.kind = k;
      r.out_byte = b;
      r.code = c;
      r.offset = off[31:0];
      r.value = v;
      r.last = 1'b0;
      utf8_expected_q.push_back(r);
      step_count++;
   endfunction

   function automatic void raise_error(logic [3:0] c, longint unsigned off,
                                       logic signed [21:0] v);
      push_result(ust_pkg::KIND_ERROR, 8'h00, c, off, v);
      stream_failed = 1'b1;
      seq_got = 0;
   endfunction

   function automatic bit yaml_legal(logic [20:0] v);
      return v == 21'h09 || v == 21'h0A || v == 21'h0D || (v >= 21'h20 && v <= 21'h7E)
         || v == 21'h85 || (v >= 21'hA0 && v <= 21'hD7FF)
         || (v >= 21'hE000 && v <= 21'hFFFD) || (v >= 21'h10000 && v <= 21'h10FFFF);
   endfunction

   function automatic void write_utf8(logic [20:0] v, longint unsigned start);
      if (!yaml_legal(v)) begin
         raise_error(ust_pkg::ERR_DISALLOWED, start, 22'(v));
         return;
      end
      if (v <= 21'h7F) begin
         push_result(ust_pkg::KIND_BYTE, v[7:0], 4'd0, 0, '0);
      end else if (v <= 21'h7FF) begin
         push_result(ust_pkg::KIND_BYTE, 8'hC0 | 8'(v >> 6), 4'd0, 0, '0);
         push_result(ust_pkg::KIND_BYTE, 8'h80 | 8'(v[5:0]), 4'd0, 0, '0);
      end else if (v <= 21'hFFFF) begin
         push_result(ust_pkg::KIND_BYTE, 8'hE0 | 8'(v >> 12), 4'd0, 0, '0);
         push_result(ust_pkg::KIND_BYTE, 8'h80 | 8'(v[11:6]), 4'd0, 0, '0);
         push_result(ust_pkg::KIND_BYTE, 8'h80 | 8'(v[5:0]), 4'd0, 0, '0);
      end else begin
         push_result(ust_pkg::KIND_BYTE, 8'hF0 | 8'(v >> 18), 4'd0, 0, '0);
         push_result(ust_pkg::KIND_BYTE, 8'h80 | 8'(v[17:12]), 4'd0, 0, '0);
         push_result(ust_pkg::KIND_BYTE, 8'h80 | 8'(v[11:6]), 4'd0, 0, '0);
         push_result(ust_pkg::KIND_BYTE, 8'h80 | 8'(v[5:0]), 4'd0, 0, '0);
      end
   endfunction

   function automatic longint unsigned seq_start(longint unsigned pos);
      return pos >= seq_got ? pos - seq_got : 0;
   endfunction

   function automatic void decode_utf8(logic [7:0] b, longint unsigned pos);
      longint unsigned start;
      int unsigned w;
      logic [20:0] v;
      if (seq_got == 0) begin
         if (b < 8'h80) begin
            write_utf8(21'(b), pos);
            return;
         end
         w = (b & 8'hE0) == 8'hC0 ? 2 : (b & 8'hF0) == 8'hE0 ? 3 :
             (b & 8'hF8) == 8'hF0 ? 4 : 0;
         if (w == 0) begin
            raise_error(ust_pkg::ERR_BAD_LEAD, pos, 22'(b));
            return;
         end
         acc = w == 2 ? 21'(b & 8'h1F) : w == 3 ? 21'(b & 8'h0F) : 21'(b & 8'h07);
         seq_len = w;
         seq_got = 1;
         trail_err = 1'b0;
         return;
      end
      start = seq_start(pos);
      if ((b & 8'hC0) != 8'h80 && !trail_err) begin
         trail_err = 1'b1;
         trail_at = pos;
         trail_val = b;
      end
      acc = (acc << 6) + 21'(b[5:0]);
      seq_got++;
      if (seq_got < seq_len) return;
      seq_got = 0;
      v = acc;
      w = seq_len;
      if (trail_err) begin
         raise_error(ust_pkg::ERR_BAD_TRAIL, trail_at, 22'(trail_val));
         return;
      end
      if ((w == 2 && v < 21'h80) || (w == 3 && v < 21'h800) || (w == 4 && v < 21'h10000)) begin
         raise_error(ust_pkg::ERR_OVERLONG, start, -22'sd1);
         return;
      end
      if ((v >= 21'hD800 && v <= 21'hDFFF) || v > 21'h10FFFF) begin
         raise_error(ust_pkg::ERR_BAD_CODEPOINT, start, 22'(v));
         return;
      end
      write_utf8(v, start);
   endfunction

   function automatic void decode_utf16(logic [7:0] b, longint unsigned pos);
      longint unsigned start;
      logic [15:0] unit;
      start = seq_start(pos);
      if (seq_got == 0 || seq_got == 2) begin
         acc = 21'(b);
         seq_got++;
         return;
      end
      unit = cur_enc == ust_pkg::ENC_UTF16LE ? {b, acc[7:0]} : {acc[7:0], b};
      if (seq_got == 1) begin
         if ((unit & 16'hFC00) == 16'hDC00) begin
            raise_error(ust_pkg::ERR_STRAY_LOW, start, 22'(unit));
            return;
         end
         if ((unit & 16'hFC00) == 16'hD800) begin
            high_sur = unit;
            seq_got = 2;
            return;
         end
         seq_got = 0;
         write_utf8(21'(unit), start);
         return;
      end
      seq_got = 0;
      if ((unit & 16'hFC00) != 16'hDC00) begin
         raise_error(ust_pkg::ERR_MISSING_LOW, start + 2, 22'(unit));
         return;
      end
      write_utf8(21'h10000 + (21'(high_sur[9:0]) << 10) + 21'(unit[9:0]), start);
   endfunction

   function automatic void decode_byte(logic [7:0] b, longint unsigned pos);
      if (cur_enc == ust_pkg::ENC_UTF8) decode_utf8(b, pos);
      else decode_utf16(b, pos);
   endfunction

   function automatic void flush_marks();
      cur_enc = ust_pkg::ENC_UTF8;
      for (int unsigned i = 0; i < held_count && i < 3 && !stream_failed; i++)
         decode_utf8(held_mark[i], i);
      held_count = 0;
   endfunction

   function automatic void sniff_mark(logic [7:0] b, longint unsigned pos);
      int unsigned n;
      n = held_count > 2 ? 2 : held_count;
      held_mark[n] = b;
      held_count = n + 1;
      if (n == 0) begin
         if (b != 8'hEF && b != 8'hFE && b != 8'hFF) begin
            held_count = 0;
            cur_enc = ust_pkg::ENC_UTF8;
            decode_utf8(b, pos);
         end
         return;
      end
      if (n == 1) begin
         if (held_mark[0] == 8'hFF && b == 8'hFE) begin
            cur_enc = ust_pkg::ENC_UTF16LE;
            held_count = 0;
         end else if (held_mark[0] == 8'hFE && b == 8'hFF) begin
            cur_enc = ust_pkg::ENC_UTF16BE;
            held_count = 0;
         end else if (!(held_mark[0] == 8'hEF && b == 8'hBB)) begin
            flush_marks();
         end
         return;
      end
      if (b == 8'hBF) begin
         cur_enc = ust_pkg::ENC_UTF8;
         held_count = 0;
      end else begin
         flush_marks();
      end
   endfunction

   function automatic void close_stream();
      if (cur_enc == ust_pkg::ENC_UTF8 && seq_got > 0)
         raise_error(ust_pkg::ERR_INCOMPLETE_UTF8, seq_start(rx_offset), -22'sd1);
      else if (cur_enc != ust_pkg::ENC_UTF8 && seq_got == 1)
         raise_error(ust_pkg::ERR_INCOMPLETE_UTF16, seq_start(rx_offset), -22'sd1);
      else if (cur_enc != ust_pkg::ENC_UTF8 && seq_got >= 2)
         raise_error(ust_pkg::ERR_INCOMPLETE_PAIR, seq_start(rx_offset), -22'sd1);
      else begin
         push_result(ust_pkg::KIND_END, 8'h00, 4'd0, 0, '0);
         stream_done = 1'b1;
      end
   endfunction

   function automatic void predict_transaction(bit is_end, logic [7:0] b);
      longint unsigned pos;
      step_count = 0;
      if (stream_failed || stream_done) return;
      if (is_end) begin
         if (cur_enc == ust_pkg::ENC_AUTO) begin
            if (held_count > 0) flush_marks();
            else if (mode_reg != ust_pkg::ENC_AUTO) cur_enc = ust_pkg::enc_type'(mode_reg);
            else cur_enc = ust_pkg::ENC_UTF8;
         end
         if (!stream_failed) close_stream();
      end else begin
         pos = rx_offset;
         if (pos >= longint'(limit_reg)) begin
            raise_error(ust_pkg::ERR_TOO_LONG, pos, -22'sd1);
         end else begin
            if (pos < OFFSET_MAX) rx_offset = pos + 1;
            if (cur_enc == ust_pkg::ENC_AUTO && held_count == 0
                && mode_reg != ust_pkg::ENC_AUTO) begin
               cur_enc = ust_pkg::enc_type'(mode_reg);
               decode_byte(b, pos);
            end else if (cur_enc == ust_pkg::ENC_AUTO) begin
               sniff_mark(b, pos);
            end else begin
               decode_byte(b, pos);
            end
         end
      end
      if (step_count > 0) begin
         utf8_expected_q[$].last = 1'b1;
         last_predicted = utf8_expected_q[$];
         predicted_total += step_count;
      end
   endfunction

   // response checker and ready generator
   always @(posedge clock) begin
      utf8_result_type got, want;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.kind, rsp.out_byte, rsp.error_code, rsp.error_offset,
                    rsp.error_value, rsp.last};
            if (utf8_expected_q.size() == 0) begin
               errors++;
               $display("%0t unexpected transaction: kind %0d byte %h code %0d off %0d val %0d",
                        $time, got.kind, got.out_byte, got.code, got.offset, got.value);
            end else begin
               want = utf8_expected_q.pop_front();
               checked++;
               if (got !== want) begin
                  errors++;
                  $display("%0t mismatch: expected kind %0d byte %h code %0d off %0d val %0d last %0d",
                           $time, want.kind, want.out_byte, want.code, want.offset, want.value,
                           want.last);
                  $display("%0t          actual kind %0d byte %h code %0d off %0d val %0d last %0d",
                           $time, got.kind, got.out_byte, got.code, got.offset, got.value,
                           got.last);
               end
            end
         end
         rsp.ready <= !gaps_on || $urandom_range(99) >= 20;
      end
   end

   task automatic send_transaction(bit is_end, logic [7:0] b);
      while (gaps_on && $urandom_range(99) < 20) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.action <= is_end;
      req.in_byte <= b;
      do @(posedge clock); while (!req.ready);
      predict_transaction(is_end, b);
   endtask

   task automatic csr_write(ust_pkg::csr_index_type idx, logic [31:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == ust_pkg::CSR_ENCODING_MODE) mode_reg = data[1:0];
      else limit_reg = data;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      req.valid <= 1'b0;
      while (utf8_expected_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   function automatic void encode_char(logic [20:0] cp);
      logic [15:0] units [$];
      logic [20:0] u;
      if (stream_enc == ust_pkg::ENC_UTF8) begin
         if (cp <= 21'h7F) begin
            byte_q.push_back(cp[7:0]);
         end else if (cp <= 21'h7FF) begin
            byte_q.push_back(8'hC0 | 8'(cp >> 6));
            byte_q.push_back(8'h80 | 8'(cp[5:0]));
         end else if (cp <= 21'hFFFF) begin
            byte_q.push_back(8'hE0 | 8'(cp >> 12));
            byte_q.push_back(8'h80 | 8'(cp[11:6]));
            byte_q.push_back(8'h80 | 8'(cp[5:0]));
         end else begin
            byte_q.push_back(8'hF0 | 8'(cp >> 18));
            byte_q.push_back(8'h80 | 8'(cp[17:12]));
            byte_q.push_back(8'h80 | 8'(cp[11:6]));
            byte_q.push_back(8'h80 | 8'(cp[5:0]));
         end
         return;
      end
      if (cp >= 21'h10000) begin
         u = cp - 21'h10000;
         units.push_back(16'hD800 | 16'(u >> 10));
         units.push_back(16'hDC00 | 16'(u[9:0]));
      end else begin
         units.push_back(cp[15:0]);
      end
      foreach (units[i]) begin
         if (stream_enc == ust_pkg::ENC_UTF16LE) begin
            byte_q.push_back(units[i][7:0]);
            byte_q.push_back(units[i][15:8]);
         end else begin
            byte_q.push_back(units[i][15:8]);
            byte_q.push_back(units[i][7:0]);
         end
      end
   endfunction

   task automatic send_bytes();
      while (byte_q.size() != 0) send_transaction(1'b0, byte_q.pop_front());
   endtask

   function automatic logic [20:0] random_char();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 5) return r[0] ? 21'h0A : ($urandom_range(1) ? 21'h09 : 21'h0D);
      if (r < 40) return 21'($urandom_range(8'h7E, 8'h20));
      if (r < 43) return 21'h85;
      if (r < 60) return 21'($urandom_range(21'h7FF, 21'hA0));
      if (r < 70) return 21'($urandom_range(21'hD7FF, 21'h800));
      if (r < 80) return 21'($urandom_range(21'hFFFD, 21'hE000));
      return 21'($urandom_range(21'h10FFFF, 21'h10000));
   endfunction

   char_row_type directed [] = '{
      '{21'h09, 1}, '{21'h0A, 1}, '{21'h0D, 1}, '{21'h20, 1}, '{21'h7E, 1},
      '{21'h41, 1}, '{21'h85, 0}, '{21'hA0, 0}, '{21'hFF, 0}, '{21'h7FF, 0},
      '{21'h800, 0}, '{21'hD7FF, 0}, '{21'hE000, 0}, '{21'hFFFD, 0},
      '{21'h10000, 0}, '{21'h10FFFF, 0}, '{21'h7F, 0}, '{21'h3FF0F, 0}
   };

   initial begin
      int unsigned sel, ending, before_total;
      string ending_name;
      reset = 1'b1;
      req.valid = 1'b0;
      req.action = 1'b0;
      req.in_byte = 8'h00;
      csr_write_enable = 1'b0;
      csr_index = ust_pkg::CSR_ENCODING_MODE;
      csr_write_data = '0;
      mode_reg = ust_pkg::ENC_AUTO;
      limit_reg = 32'hFFFF_FFFF;
      cur_enc = ust_pkg::ENC_AUTO;
      held_count = 0;
      acc = '0;
      seq_len = 0;
      seq_got = 0;
      high_sur = '0;
      rx_offset = 0;
      stream_failed = 0;
      stream_done = 0;
      trail_err = 0;
      errors = 0;
      checked = 0;
      predicted_total = 0;
      chars_sent = 0;
      gaps_on = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      csr_write(ust_pkg::CSR_MAX_LENGTH, 32'd1);
      csr_write(ust_pkg::CSR_ENCODING_MODE, ust_pkg::ENC_UTF16BE);
      csr_write(ust_pkg::CSR_MAX_LENGTH, 32'hFFFF_FFFF);
      sel = $urandom_range(6);
      case (sel)
         0: begin
            csr_write(ust_pkg::CSR_ENCODING_MODE, ust_pkg::ENC_AUTO);
            stream_enc = ust_pkg::ENC_UTF8;
         end
         1: begin
            csr_write(ust_pkg::CSR_ENCODING_MODE, ust_pkg::ENC_AUTO);
            stream_enc = ust_pkg::ENC_UTF8;
            byte_q = '{8'hEF, 8'hBB, 8'hBF};
         end
         2: begin
            csr_write(ust_pkg::CSR_ENCODING_MODE, ust_pkg::ENC_AUTO);
            stream_enc = ust_pkg::ENC_UTF16LE;
            byte_q = '{8'hFF, 8'hFE};
         end
         3: begin
            csr_write(ust_pkg::CSR_ENCODING_MODE, ust_pkg::ENC_AUTO);
            stream_enc = ust_pkg::ENC_UTF16BE;
            byte_q = '{8'hFE, 8'hFF};
         end
         default: begin
            stream_enc = ust_pkg::enc_type'(sel - 3);
            csr_write(ust_pkg::CSR_ENCODING_MODE, stream_enc);
         end
      endcase
      send_bytes();

      foreach (directed[i]) begin
         before_total = predicted_total;
         encode_char(directed[i].cp);
         send_bytes();
         chars_sent++;
         if (directed[i].typed && (predicted_total != before_total + 1
               || last_predicted.kind != ust_pkg::KIND_BYTE
               || last_predicted.out_byte != directed[i].cp[7:0])) begin
            errors++;
            $display("%0t directed mismatch: expected byte %h actual byte %h",
                     $time, directed[i].cp[7:0], last_predicted.out_byte);
         end
      end
      wait_drained();

      // mode is latched at the first byte, so these writes must not disturb the stream
      csr_write(ust_pkg::CSR_ENCODING_MODE, ust_pkg::ENC_AUTO);
      csr_write(ust_pkg::CSR_ENCODING_MODE, ust_pkg::ENC_UTF16LE);
      csr_write(ust_pkg::CSR_MAX_LENGTH, 32'hFFFF_FFFF);

      for (int i = 0; i < 150; i++) begin
         gaps_on = !(i >= 60 && i < 110);
         if (i == 120) wait_drained();
         encode_char(random_char());
         send_bytes();
         chars_sent++;
      end
      gaps_on = 1'b1;

      ending = $urandom_range(3);
      case (ending)
         0: begin
            ending_name = "end of stream";
            send_transaction(1'b1, 8'h00);
         end
         1: begin
            ending_name = "length limit";
            wait_drained();
            csr_write(ust_pkg::CSR_MAX_LENGTH, 32'(rx_offset));
            send_transaction(1'b0, 8'($urandom));
         end
         2: begin
            ending_name = "random bytes";
            for (int i = 0; i < 16 && !stream_failed; i++) send_transaction(1'b0, 8'($urandom));
            if (!stream_failed) send_transaction(1'b1, 8'h00);
         end
         default: begin
            ending_name = "truncated character";
            encode_char(21'($urandom_range(21'h10FFFF, 21'h10000)));
            void'(byte_q.pop_back());
            send_bytes();
            send_transaction(1'b1, 8'h00);
         end
      endcase
      for (int i = 0; i < 6; i++) send_transaction($urandom_range(1), 8'($urandom));
      req.valid <= 1'b0;

      while (utf8_expected_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("stream of %0d characters, %0d bytes, encoding %s, closed by %s",
               chars_sent, rx_offset, stream_enc.name(), ending_name);
      $display("%0d output transactions checked, %0d errors", checked, errors);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
